FILE: src/lsws_pkg.sv
// ----------------------------------------------------------------------------
// lsws_pkg
// Types and constants shared by the stream window scheduler and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lsws_pkg;

	localparam int IDX_W  = 24;
	localparam int ADV_W  = 32;
	localparam int KIND_W = 2;
	localparam int CFG_W  = 2;
	localparam int FILL_W = 4;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP      = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADVANCE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RESTART  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_W-1:0] REG_TOTAL_SAMPLES = 2'd0;
	localparam logic [CFG_W-1:0] REG_LOOP_ENABLE   = 2'd1;
	localparam logic [CFG_W-1:0] REG_START_CURSOR  = 2'd2;
	localparam logic [CFG_W-1:0] REG_MAX_SAMPLES   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] start;
		logic [IDX_W-1:0] count;
		logic [IDX_W-1:0] next;
		logic             at_end;
		logic             wrap;
	} plan_t;

	typedef struct packed {
		logic  ok;
		plan_t plan;
	} result_t;

endpackage

`default_nettype wire

FILE: src/looping_stream_window_scheduler.sv
// ----------------------------------------------------------------------------
// looping_stream_window_scheduler
// Play cursor over a sample buffer with a ring queue of planned refill windows.
// ----------------------------------------------------------------------------
// Usage:
//   input channel item_valid/item_ready carries one word of kind,
//   requested_samples and advance_samples; the result channel
//   result_valid/result_ready returns exactly one word per item.
//   configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Sequence:
//   schedule, pop, restart and non-wrapping advance: the item is evaluated in
//   ST_EVAL, its result is loaded into the output register from ST_DONE, and
//   the next item is taken in ST_IDLE after that. a looping advance that passes
//   the buffer end first runs the modulo through a one-bit-per-cycle divider.
// Stall:
//   the result sits in an output register; a new item is accepted while it
//   waits, but that item's result holds in the sequencer until the output
//   register is taken.
// Reset:
//   arst_n clears the config registers, state, cursor, queue pointers and the output valid.
//   the plan memory is not cleared; only written entries are ever popped.
// ----------------------------------------------------------------------------
`default_nettype none

module looping_stream_window_scheduler
	import lsws_pkg::*;
#(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_index,
	input  wire logic [IDX_W-1:0]  cfg_data,

	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [IDX_W-1:0]  requested_samples,
	input  wire logic [ADV_W-1:0]  advance_samples,

	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic                   ok,
	output logic [IDX_W-1:0]       window_start,
	output logic [IDX_W-1:0]       window_count,
	output logic [IDX_W-1:0]       window_next,
	output logic                   reached_end,
	output logic                   wrapped,
	output logic [IDX_W-1:0]       cursor_now,
	output logic [FILL_W-1:0]      queue_fill
);

	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SUM_W  = CNT_W + 1;
	localparam int STEP_W = $clog2(ADV_W);

	localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ADV_W - 1);

	// configuration
	logic [IDX_W-1:0] total_q;
	logic             loop_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] max_q;

	// sequencer and state
	state_t            state_q, state_d;
	logic [KIND_W-1:0] kind_q;
	logic [IDX_W-1:0]  req_q;
	logic [ADV_W-1:0]  adv_q;
	logic [IDX_W-1:0]  cursor_q;
	logic [PTR_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	result_t           res_q;

	// plan memory
	plan_t plan_mem_q [QUEUE_DEPTH];
	plan_t rd_q;

	// divider
	logic [IDX_W-1:0]  rem_q;
	logic [ADV_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic [IDX_W:0]    trial;
	logic [IDX_W:0]    trial_diff;
	logic [IDX_W-1:0]  rem_next;

	// output register
	logic              result_valid_q;
	result_t           out_q;
	logic [IDX_W-1:0]  out_cursor_q;
	logic [FILL_W-1:0] out_fill_q;

	// sequencer controls
	logic do_accept, do_eval, do_step, do_load;

	// evaluation
	logic             sok, at_total, cur_over, req_end, adv_end;
	logic [IDX_W-1:0] base, avail, cnt, sched_next, adv_sum;
	logic [ADV_W-1:0] dividend;
	logic [SUM_W-1:0] tail_sum;
	logic [PTR_W-1:0] tail_ptr, head_inc;
	result_t          ev_res;
	logic             ev_cur_we, ev_push, ev_pop, ev_clear, ev_div;
	logic [IDX_W-1:0] ev_cur_d;

	always_comb begin
		sok        = (total_q != '0) && (max_q != '0) && (total_q <= max_q);
		at_total   = cursor_q == total_q;
		cur_over   = cursor_q > total_q;
		base       = at_total ? '0 : cursor_q;
		avail      = total_q - base;
		req_end    = req_q >= avail;
		cnt        = req_end ? avail : req_q;
		sched_next = req_end ? (loop_q ? '0 : total_q) : base + req_q;
		adv_end    = adv_q >= ADV_W'(avail);
		adv_sum    = base + adv_q[IDX_W-1:0];
		dividend   = adv_q - ADV_W'(avail);
		tail_sum   = SUM_W'(head_q) + SUM_W'(count_q);
		tail_ptr   = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
			: PTR_W'(tail_sum);
		head_inc   = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
	end

	always_comb begin
		ev_res    = '0;
		ev_cur_we = 1'b0;
		ev_cur_d  = cursor_q;
		ev_push   = 1'b0;
		ev_pop    = 1'b0;
		ev_clear  = 1'b0;
		ev_div    = 1'b0;
		case (kind_q)
			KIND_SCHEDULE: begin
				if (count_q < DEPTH_CNT && sok && req_q != '0 && req_q <= max_q
						&& !cur_over && !(at_total && !loop_q)) begin
					ev_res.ok          = 1'b1;
					ev_res.plan.start  = base;
					ev_res.plan.count  = cnt;
					ev_res.plan.next   = sched_next;
					ev_res.plan.at_end = req_end;
					ev_res.plan.wrap   = at_total || (loop_q && req_end);
					ev_push            = 1'b1;
					ev_cur_we          = 1'b1;
					ev_cur_d           = sched_next;
				end
			end
			KIND_POP: begin
				if (count_q != '0) begin
					ev_res.ok   = 1'b1;
					ev_res.plan = rd_q;
					ev_pop      = 1'b1;
				end
			end
			KIND_ADVANCE: begin
				if (sok && !cur_over) begin
					ev_res.ok = 1'b1;
					if (!loop_q && at_total) begin
						ev_res.plan.at_end = 1'b1;
					end else if (!loop_q) begin
						ev_res.plan.at_end = adv_end;
						ev_cur_we          = 1'b1;
						ev_cur_d           = adv_end ? total_q : adv_sum;
					end else begin
						ev_res.plan.at_end = adv_end;
						ev_res.plan.wrap   = at_total || adv_end;
						// past the end: cursor comes from the divider
						ev_div             = adv_end;
						ev_cur_we          = !adv_end;
						ev_cur_d           = adv_sum;
					end
				end
			end
			KIND_RESTART: begin
				if (sok && start_q <= total_q) begin
					ev_res.ok = 1'b1;
					ev_cur_we = 1'b1;
					ev_cur_d  = start_q;
					ev_clear  = 1'b1;
				end
			end
			default: begin
				ev_res = '0;
			end
		endcase
	end

	// one restoring remainder step per cycle
	always_comb begin
		trial      = {rem_q, quo_q[ADV_W-1]};
		trial_diff = trial - {1'b0, total_q};
		rem_next   = trial_diff[IDX_W] ? trial[IDX_W-1:0] : trial_diff[IDX_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ev_div ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				if (step_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_ready = 1'b0;
		do_eval    = 1'b0;
		do_step    = 1'b0;
		do_load    = 1'b0;
		case (state_q)
			ST_IDLE: item_ready = 1'b1;
			ST_EVAL: do_eval = 1'b1;
			ST_DIV:  do_step = 1'b1;
			ST_DONE: do_load = !result_valid_q || result_ready;
			default: item_ready = 1'b0;
		endcase
		do_accept = item_ready && item_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q        <= '0;
			loop_q         <= 1'b0;
			start_q        <= '0;
			max_q          <= '0;
			state_q        <= ST_IDLE;
			cursor_q       <= '0;
			head_q         <= '0;
			count_q        <= '0;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TOTAL_SAMPLES: total_q <= cfg_data;
					REG_LOOP_ENABLE:   loop_q  <= cfg_data[0];
					REG_START_CURSOR:  start_q <= cfg_data;
					REG_MAX_SAMPLES:   max_q   <= cfg_data;
					default:           total_q <= total_q;
				endcase
			end
			state_q <= state_d;
			if (do_eval) begin
				if (ev_cur_we) cursor_q <= ev_cur_d;
				if (ev_push) count_q <= count_q + CNT_W'(1);
				if (ev_pop) begin
					count_q <= count_q - CNT_W'(1);
					head_q  <= head_inc;
				end
				if (ev_clear) begin
					count_q <= '0;
					head_q  <= '0;
				end
				if (ev_div) step_q <= LAST_STEP;
			end
			if (do_step) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) cursor_q <= rem_next;
			end
			if (do_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (do_accept) begin
			kind_q <= kind;
			req_q  <= requested_samples;
			adv_q  <= advance_samples;
		end
		if (do_eval) begin
			res_q <= ev_res;
			rem_q <= '0;
			quo_q <= dividend;
		end
		if (do_step) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[ADV_W-2:0], 1'b0};
		end
		if (do_load) begin
			out_q        <= res_q;
			out_cursor_q <= cursor_q;
			out_fill_q   <= FILL_W'(count_q);
		end
	end

	// plan memory: one write port, one registered read port at the head
	always_ff @(posedge clk) begin
		if (do_eval && ev_push) plan_mem_q[tail_ptr] <= ev_res.plan;
	end

	always_ff @(posedge clk) begin
		rd_q <= plan_mem_q[head_q];
	end

	assign result_valid = result_valid_q;
	assign ok           = out_q.ok;
	assign window_start = out_q.plan.start;
	assign window_count = out_q.plan.count;
	assign window_next  = out_q.plan.next;
	assign reached_end  = out_q.plan.at_end;
	assign wrapped      = out_q.plan.wrap;
	assign cursor_now   = out_cursor_q;
	assign queue_fill   = out_fill_q;

endmodule

`default_nettype wire

FILE: src/lsws_checker.sv
// ----------------------------------------------------------------------------
// lsws_checker
// Port-level checks on the stream window scheduler, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsws_checker
	import lsws_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_ready,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire logic              ok,
	input wire logic [IDX_W-1:0]  window_start,
	input wire logic [IDX_W-1:0]  window_count,
	input wire logic [IDX_W-1:0]  window_next,
	input wire logic              reached_end,
	input wire logic              wrapped,
	input wire logic [IDX_W-1:0]  cursor_now,
	input wire logic [FILL_W-1:0] queue_fill
);

	// a stalled result word holds (the end and wrap flags are not checked)
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(ok)
			&& $stable(window_start) && $stable(window_count)
			&& $stable(window_next) && $stable(cursor_now)
			&& $stable(queue_fill))
		else $error("result word changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item accepted while one is in work");

	// rejected words carry no window and no flags
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !ok |-> window_start == '0 && window_count == '0
			&& window_next == '0 && !reached_end && !wrapped)
		else $error("rejected word carries window data");

	// unless a window ends and wraps, it continues right after itself
	a_window_next: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ok && window_count != '0 && !(reached_end && wrapped)
			|-> window_next == window_start + window_count)
		else $error("window next does not follow window");

endmodule

bind looping_stream_window_scheduler lsws_checker u_lsws_checker (.*);

`default_nettype wire
